// ----- src/btec_pkg.sv -----
`timescale 1ns / 1ps

package btec_pkg;

  localparam int PIXEL_BITS_DEF = 8;
  localparam int REG_BITS       = 8;
  localparam int INDEX_BITS     = 8;
  localparam int WINDOW_DEPTH   = 3;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [INDEX_BITS-1:0] REG_LOW_THR  = 8'd0;
  localparam logic [INDEX_BITS-1:0] REG_HIGH_THR = 8'd1;
  localparam logic [INDEX_BITS-1:0] REG_MARGIN   = 8'd2;
  localparam logic [INDEX_BITS-1:0] REG_STEP     = 8'd3;

  localparam logic [REG_BITS-1:0] LOW_THR_RST  = 8'd115;
  localparam logic [REG_BITS-1:0] HIGH_THR_RST = 8'd140;
  localparam logic [REG_BITS-1:0] MARGIN_RST   = 8'd5;
  localparam logic [REG_BITS-1:0] STEP_RST     = 8'd12;

  typedef struct packed {
    logic [REG_BITS-1:0] low_thr;
    logic [REG_BITS-1:0] high_thr;
    logic [REG_BITS-1:0] margin;
    logic [REG_BITS-1:0] step;
  } cfg_t;

  typedef struct packed {
    logic defect;
    logic row_done;
  } result_t;

endpackage

// ----- src/band_threshold_edge_classifier.sv -----
`timescale 1ns / 1ps

// Classifies one grey pixel per clock, when in_ready is high, into a defect mask bit.
// A pixel's mask bit leaves one request after the pixel itself, since the edge test
// looks at the next pixel; the last pixel of a row (row_last) is flushed in the same
// request and gives a second result marked row_done. Sustained rate is one pixel per
// cycle while in_ready is high; results go through a four-entry queue, and a row end
// takes one extra output slot, which the queue absorbs while out_ready stays high. The
// input stalls only when the queue has fewer than two free entries. Registers (index
// 0..3): low threshold, high threshold, near margin, edge step; write them only while idle.
module band_threshold_edge_classifier #(
  parameter int PIXEL_BITS = btec_pkg::PIXEL_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [PIXEL_BITS-1:0]           pixel,
  input  logic                            row_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            defect,
  output logic                            row_done,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [btec_pkg::INDEX_BITS-1:0] cfg_index,
  input  logic [btec_pkg::REG_BITS-1:0]   cfg_data
);

  localparam int WIN = btec_pkg::WINDOW_DEPTH;

  btec_pkg::cfg_t    cfg;
  btec_pkg::result_t res_pend;
  btec_pkg::result_t res_last;
  btec_pkg::result_t res_a;
  btec_pkg::result_t q_data;
  logic [PIXEL_BITS-1:0] win_q [WIN];
  logic [WIN-1:0]        win_occ;
  logic                  in_fire;
  logic                  shift;
  logic                  clear;
  logic                  pend_defect;
  logic                  last_defect;
  logic                  push_a;
  logic                  push_b;
  logic                  room2;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_thr  <= btec_pkg::LOW_THR_RST;
      cfg.high_thr <= btec_pkg::HIGH_THR_RST;
      cfg.margin   <= btec_pkg::MARGIN_RST;
      cfg.step     <= btec_pkg::STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        btec_pkg::REG_LOW_THR:  cfg.low_thr  <= cfg_data;
        btec_pkg::REG_HIGH_THR: cfg.high_thr <= cfg_data;
        btec_pkg::REG_MARGIN:   cfg.margin   <= cfg_data;
        btec_pkg::REG_STEP:     cfg.step     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = room2;
  assign in_fire  = in_valid && in_ready;
  assign shift    = in_fire && !row_last;
  assign clear    = in_fire && row_last;

  btec_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell0 (
    .clk     (clk),
    .rst     (rst),
    .shift   (shift),
    .clear   (clear),
    .din     (pixel),
    .din_occ (1'b1),
    .q       (win_q[0]),
    .occ     (win_occ[0])
  );

  for (genvar i = 1; i < WIN; i++) begin : g_cell
    btec_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (shift),
      .clear   (clear),
      .din     (win_q[i-1]),
      .din_occ (win_occ[i-1]),
      .q       (win_q[i]),
      .occ     (win_occ[i])
    );
  end

  btec_classify #(.PIXEL_BITS(PIXEL_BITS)) u_classify (
    .cfg         (cfg),
    .cur         (win_q[0]),
    .back2       (win_q[WIN-1]),
    .px          (pixel),
    .pend_full   (win_occ[WIN-1]),
    .pend_defect (pend_defect),
    .last_defect (last_defect)
  );

  assign res_pend = '{defect: pend_defect, row_done: 1'b0};
  assign res_last = '{defect: last_defect, row_done: 1'b1};
  assign push_a   = in_fire && (win_occ[0] || row_last);
  assign push_b   = in_fire && win_occ[0] && row_last;
  assign res_a    = win_occ[0] ? res_pend : res_last;

  btec_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_a    (push_a),
    .data_a    (res_a),
    .push_b    (push_b),
    .data_b    (res_last),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (q_data)
  );

  assign defect   = q_data.defect;
  assign row_done = q_data.row_done;

`ifndef SYNTH
  a_row_end_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && row_last |=> (win_occ == '0))
    else $error("window not cleared after row end");

  a_shift_fills: assert property (@(posedge clk) disable iff (rst)
    in_fire && !row_last |=> win_occ[0] && (win_occ[1] == $past(win_occ[0])))
    else $error("window occupancy did not advance");

  a_occ_thermo: assert property (@(posedge clk) disable iff (rst)
    (win_occ[0] || (win_occ == '0)) && (!win_occ[2] || win_occ[1]))
    else $error("window occupancy not contiguous");

  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    !room2 |-> !in_fire)
    else $error("pixel taken without queue room");
`endif

endmodule

// ----- src/btec_cell.sv -----
`timescale 1ns / 1ps

module btec_cell #(
  parameter int PIXEL_BITS = btec_pkg::PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  shift,
  input  logic                  clear,
  input  logic [PIXEL_BITS-1:0] din,
  input  logic                  din_occ,
  output logic [PIXEL_BITS-1:0] q,
  output logic                  occ
);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (clear) begin
      occ <= 1'b0;
    end else if (shift) begin
      occ <= din_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= din;
    end
  end

endmodule

// ----- src/btec_classify.sv -----
`timescale 1ns / 1ps

module btec_classify #(
  parameter int PIXEL_BITS = btec_pkg::PIXEL_BITS_DEF
) (
  input  btec_pkg::cfg_t        cfg,
  input  logic [PIXEL_BITS-1:0] cur,
  input  logic [PIXEL_BITS-1:0] back2,
  input  logic [PIXEL_BITS-1:0] px,
  input  logic                  pend_full,
  output logic                  pend_defect,
  output logic                  last_defect
);

  logic [PIXEL_BITS-1:0] low_w;
  logic [PIXEL_BITS-1:0] high_w;
  logic [PIXEL_BITS-1:0] margin_w;
  logic [PIXEL_BITS-1:0] step_w;
  logic [PIXEL_BITS-1:0] diff_low;
  logic [PIXEL_BITS-1:0] diff_high;
  logic [PIXEL_BITS-1:0] diff_edge;
  logic                  cur_out;
  logic                  cur_near;

  assign low_w    = PIXEL_BITS'(cfg.low_thr);
  assign high_w   = PIXEL_BITS'(cfg.high_thr);
  assign margin_w = PIXEL_BITS'(cfg.margin);
  assign step_w   = PIXEL_BITS'(cfg.step);

  assign diff_low  = (cur >= low_w)  ? (cur - low_w)  : (low_w - cur);
  assign diff_high = (cur >= high_w) ? (cur - high_w) : (high_w - cur);
  assign diff_edge = (px >= back2)   ? (px - back2)   : (back2 - px);

  assign cur_out  = (cur < low_w) || (cur >= high_w);
  assign cur_near = (diff_low < margin_w) || (diff_high < margin_w);

  assign pend_defect = cur_out || (pend_full && cur_near && (diff_edge >= step_w));
  assign last_defect = (px < low_w) || (px >= high_w);

endmodule

// ----- src/btec_queue.sv -----
`timescale 1ns / 1ps

module btec_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_a,
  input  btec_pkg::result_t data_a,
  input  logic              push_b,
  input  btec_pkg::result_t data_b,
  output logic              room2,
  output logic              out_valid,
  input  logic              out_ready,
  output btec_pkg::result_t out_data
);

  localparam int DEPTH = btec_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  btec_pkg::result_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign room2     = (count <= CNT_W'(DEPTH - 2));

  always_comb begin
    count_next = count + CNT_W'(push_a) + CNT_W'(push_b) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_a) + PTR_W'(push_b);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem[wr_ptr] <= data_a;
    end
    if (push_b) begin
      mem[wr_ptr + PTR_W'(1)] <= data_b;
    end
  end

endmodule
